// ===== rtl/kbpc_pkg.sv =====
// Shared types and constants for the keyed block pool cache.
// Used by kbpc_ctrl, kbpc_dpath and keyed_block_pool_cache; no dependencies.
package kbpc_pkg;

    localparam int HANDLE_W = 4;
    localparam int INODE_W  = 64;
    localparam int OFFSET_W = 63;

    // input command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_PUT_OVER = 2'd2
    } t_status;

    // one row of the slot store: parked entries use all of it, spares only the handle
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [INODE_W-1:0]  inode;
        logic [OFFSET_W-1:0] offset;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT_RD,
        S_HIT_WR,
        S_MISS,
        S_TAKE,
        S_PUT,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic take_hit;
        logic hit_rd;
        logic hit_move;
        logic pop_spare;
        logic new_handle;
        logic pop_parked;
        logic take_rd;
        logic no_block;
        logic put_over;
        logic park;
        logic push_spare;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;
        logic scan_done;
        logic spare_nz;
        logic fresh_ok;
        logic parked_nz;
        logic put_over;
        logic key_zero;
        logic cmd_put;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/keyed_block_pool_cache.sv =====
// Top level of the keyed block pool cache.
// Depends on kbpc_pkg, kbpc_ctrl and kbpc_dpath.
//
// Pool of 4-bit block handles with a keyed cache of parked blocks. One word
// is handled at a time. A get runs a key scan, which reads one parked entry
// per cycle through the single read port of the slot store. The next word is
// accepted as soon as the result sits in the output register, while that
// result may still be stalled. The slot store needs no clearing after reset.
module keyed_block_pool_cache #(
    parameter int POOL_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [kbpc_pkg::INODE_W-1:0]    i_key_inode,
    input  logic [kbpc_pkg::OFFSET_W-1:0]   i_key_offset,
    input  logic [kbpc_pkg::HANDLE_W-1:0]   i_block_handle,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [kbpc_pkg::HANDLE_W-1:0]   o_result_handle,
    output logic                            o_hit,
    output logic [1:0]                      o_status
);

    kbpc_pkg::t_cmd cmd;
    kbpc_pkg::t_sts sts;

    kbpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kbpc_dpath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_command       (i_command),
        .i_key_inode     (i_key_inode),
        .i_key_offset    (i_key_offset),
        .i_block_handle  (i_block_handle),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_result_handle (o_result_handle),
        .o_hit           (o_hit),
        .o_status        (o_status)
    );

endmodule

// ===== rtl/kbpc_ctrl.sv =====
// Controller state machine for the keyed block pool cache.
// Depends on kbpc_pkg; drives kbpc_dpath through t_cmd and reads t_sts back.
module kbpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  kbpc_pkg::t_sts i_sts,
    output kbpc_pkg::t_cmd o_cmd
);

    kbpc_pkg::t_state r_state;
    kbpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kbpc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = kbpc_pkg::S_SCAN;
                end
            end
            kbpc_pkg::S_SCAN: begin
                // a put passes straight through the scan state
                if (i_sts.cmd_put) begin
                    n_state = kbpc_pkg::S_PUT;
                end else if (i_sts.match) begin
                    n_state = kbpc_pkg::S_HIT_RD;
                end else if (i_sts.scan_done) begin
                    n_state = kbpc_pkg::S_MISS;
                end
            end
            kbpc_pkg::S_HIT_RD: begin
                n_state = kbpc_pkg::S_HIT_WR;
            end
            kbpc_pkg::S_HIT_WR: begin
                n_state = kbpc_pkg::S_EMIT;
            end
            kbpc_pkg::S_MISS: begin
                if (i_sts.spare_nz || (!i_sts.fresh_ok && i_sts.parked_nz)) begin
                    n_state = kbpc_pkg::S_TAKE;
                end else begin
                    n_state = kbpc_pkg::S_EMIT;
                end
            end
            kbpc_pkg::S_TAKE: begin
                n_state = kbpc_pkg::S_EMIT;
            end
            kbpc_pkg::S_PUT: begin
                n_state = kbpc_pkg::S_EMIT;
            end
            kbpc_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = kbpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kbpc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            kbpc_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            kbpc_pkg::S_SCAN: begin
                o_cmd.scan     = !i_sts.cmd_put;
                o_cmd.take_hit = !i_sts.cmd_put && i_sts.match;
            end
            kbpc_pkg::S_HIT_RD: begin
                o_cmd.hit_rd = 1'b1;
            end
            kbpc_pkg::S_HIT_WR: begin
                o_cmd.hit_move = 1'b1;
            end
            kbpc_pkg::S_MISS: begin
                priority if (i_sts.spare_nz) begin
                    o_cmd.pop_spare = 1'b1;
                end else if (i_sts.fresh_ok) begin
                    o_cmd.new_handle = 1'b1;
                end else if (i_sts.parked_nz) begin
                    o_cmd.pop_parked = 1'b1;
                end else begin
                    o_cmd.no_block = 1'b1;
                end
            end
            kbpc_pkg::S_TAKE: begin
                o_cmd.take_rd = 1'b1;
            end
            kbpc_pkg::S_PUT: begin
                priority if (i_sts.put_over) begin
                    o_cmd.put_over = 1'b1;
                end else if (i_sts.key_zero) begin
                    o_cmd.push_spare = 1'b1;
                end else begin
                    o_cmd.park = 1'b1;
                end
            end
            kbpc_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/kbpc_dpath.sv =====
// Datapath for the keyed block pool cache: slot store, counts, key compare,
// result and output registers. Depends on kbpc_pkg; commanded by kbpc_ctrl.
module kbpc_dpath #(
    parameter int POOL_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kbpc_pkg::t_cmd                  i_cmd,
    output kbpc_pkg::t_sts                  o_sts,
    input  logic                            i_command,
    input  logic [kbpc_pkg::INODE_W-1:0]    i_key_inode,
    input  logic [kbpc_pkg::OFFSET_W-1:0]   i_key_offset,
    input  logic [kbpc_pkg::HANDLE_W-1:0]   i_block_handle,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [kbpc_pkg::HANDLE_W-1:0]   o_result_handle,
    output logic                            o_hit,
    output logic [1:0]                      o_status
);

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(POOL_SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // parked entries grow up from slot 0, spares down from the top slot
    kbpc_pkg::t_slot mem [POOL_SLOTS];

    kbpc_pkg::t_slot                  r_rdata;
    logic [IDX_W-1:0]                 r_rd_addr;
    logic                             r_rvld;
    logic [CNT_W-1:0]                 r_scan_idx;
    logic [CNT_W-1:0]                 r_parked;
    logic [CNT_W-1:0]                 r_spare;
    logic [CNT_W-1:0]                 r_issued;
    logic [IDX_W-1:0]                 r_hit_idx;

    logic                             r_cmd_put;
    logic [kbpc_pkg::INODE_W-1:0]     r_key_inode;
    logic [kbpc_pkg::OFFSET_W-1:0]    r_key_offset;
    logic [kbpc_pkg::HANDLE_W-1:0]    r_put_handle;

    logic [kbpc_pkg::HANDLE_W-1:0]    r_res_handle;
    logic                             r_res_hit;
    kbpc_pkg::t_status                r_res_status;

    logic                             r_ovld;
    logic [kbpc_pkg::HANDLE_W-1:0]    r_o_handle;
    logic                             r_o_hit;
    kbpc_pkg::t_status                r_o_status;

    logic                             scan_more;
    logic [CNT_W-1:0]                 last_parked;
    logic [CNT_W-1:0]                 spare_top;
    logic [CNT_W-1:0]                 spare_new;
    logic                             rd_en;
    logic [CNT_W-1:0]                 rd_addr;
    logic                             wr_en;
    logic [CNT_W-1:0]                 wr_addr;
    kbpc_pkg::t_slot                  wr_data;
    logic                             move_needed;
    logic [CNT_W:0]                   held_sum;

    assign scan_more   = r_scan_idx < r_parked;
    assign last_parked = r_parked - ONE_C;
    assign spare_top   = SLOTS_C - r_spare;
    assign spare_new   = SLOTS_C - r_spare - ONE_C;
    assign move_needed = CNT_W'(r_hit_idx) < last_parked;
    assign held_sum    = {1'b0, r_spare} + {1'b0, r_parked};

    // single read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        priority if (i_cmd.scan && scan_more) begin
            rd_en   = 1'b1;
            rd_addr = r_scan_idx;
        end else if (i_cmd.hit_rd || i_cmd.pop_parked) begin
            rd_en   = 1'b1;
            rd_addr = last_parked;
        end else if (i_cmd.pop_spare) begin
            rd_en   = 1'b1;
            rd_addr = spare_top;
        end else begin
            rd_en = 1'b0;
        end
    end

    // single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '{handle: r_put_handle, inode: r_key_inode, offset: r_key_offset};
        priority if (i_cmd.hit_move && move_needed) begin
            wr_en   = 1'b1;
            wr_addr = CNT_W'(r_hit_idx);
            wr_data = r_rdata;
        end else if (i_cmd.park && (r_parked < SLOTS_C)) begin
            wr_en   = 1'b1;
            wr_addr = r_parked;
        end else if (i_cmd.push_spare && (r_spare < SLOTS_C)) begin
            wr_en   = 1'b1;
            wr_addr = spare_new;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata   <= mem[rd_addr[IDX_W-1:0]];
            r_rd_addr <= rd_addr[IDX_W-1:0];
        end
    end

    // counts and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parked   <= '0;
            r_spare    <= '0;
            r_issued   <= '0;
            r_scan_idx <= '0;
            r_rvld     <= 1'b0;
        end else begin
            r_rvld <= i_cmd.scan && scan_more;
            if (i_cmd.load) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan && scan_more) begin
                r_scan_idx <= r_scan_idx + ONE_C;
            end
            if (i_cmd.hit_move || i_cmd.pop_parked) begin
                r_parked <= last_parked;
            end else if (i_cmd.park && (r_parked < SLOTS_C)) begin
                r_parked <= r_parked + ONE_C;
            end
            if (i_cmd.pop_spare) begin
                r_spare <= r_spare - ONE_C;
            end else if (i_cmd.push_spare && (r_spare < SLOTS_C)) begin
                r_spare <= r_spare + ONE_C;
            end
            if (i_cmd.new_handle) begin
                r_issued <= r_issued + ONE_C;
            end
        end
    end

    // request word and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_put    <= i_command;
            r_key_inode  <= i_key_inode;
            r_key_offset <= i_key_offset;
            r_put_handle <= i_block_handle;
            r_res_handle <= '0;
            r_res_hit    <= 1'b0;
            r_res_status <= kbpc_pkg::ST_OK;
        end
        if (i_cmd.take_hit) begin
            r_res_handle <= r_rdata.handle;
            r_res_hit    <= 1'b1;
            r_hit_idx    <= r_rd_addr;
        end
        if (i_cmd.take_rd) begin
            r_res_handle <= r_rdata.handle;
        end
        if (i_cmd.new_handle) begin
            r_res_handle <= kbpc_pkg::HANDLE_W'(r_issued);
        end
        if (i_cmd.no_block) begin
            r_res_status <= kbpc_pkg::ST_NO_BLOCK;
        end
        if (i_cmd.put_over) begin
            r_res_status <= kbpc_pkg::ST_PUT_OVER;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovld <= 1'b1;
        end else if (r_ovld && !i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_handle <= r_res_handle;
            r_o_hit    <= r_res_hit;
            r_o_status <= r_res_status;
        end
    end

    assign o_valid         = r_ovld;
    assign o_result_handle = r_o_handle;
    assign o_hit           = r_o_hit;
    assign o_status        = r_o_status;

    assign o_sts.match     = r_rvld && (r_rdata.inode == r_key_inode)
                             && (r_rdata.offset == r_key_offset);
    assign o_sts.scan_done = !r_rvld && !scan_more;
    assign o_sts.spare_nz  = r_spare != '0;
    assign o_sts.fresh_ok  = r_issued < SLOTS_C;
    assign o_sts.parked_nz = r_parked != '0;
    assign o_sts.put_over  = held_sum >= {1'b0, r_issued};
    assign o_sts.key_zero  = r_key_inode == '0;
    assign o_sts.cmd_put   = r_cmd_put == kbpc_pkg::CMD_PUT;
    assign o_sts.out_free  = !r_ovld || !i_stall;

    // parked and spare entries never outnumber the handles given out
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held_sum <= {1'b0, r_issued})
        else $error("parked plus spare exceeds issued");

    a_issued_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued <= SLOTS_C)
        else $error("issued count beyond pool size");

    a_move_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.hit_move || i_cmd.pop_parked) |-> (r_parked != '0))
        else $error("parked entry removed from an empty cache");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_ovld && (r_o_status == $past(r_res_status))))
        else $error("result word lost on emit");

endmodule
